>>> sv/tmcs_pkg.sv
// Package for the truncated mean cluster size block.
// Holds the word types, the fixed field widths and the reciprocal table.
// Used by every module of the block; depends on nothing.
package tmcs_pkg;

  // Default geometry of the packed size word
  localparam int NUM_LAYERS_DEF = 10;
  localparam int SIZE_BITS_DEF  = 6;

  // Fixed field widths
  localparam int PACKED_W  = 64;
  localparam int CNT_W     = 4;
  localparam int FRAC_BITS = 8;
  localparam int MEAN_W    = 18;
  localparam int TRUNC_W   = 14;
  localparam int SUM_W     = MEAN_W - FRAC_BITS;

  // Reciprocal divide: q = (n * ceil(2^SHIFT / d)) >> SHIFT, exact for n < 2^MEAN_W, d < 16
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  localparam logic [CNT_W-1:0] TRUNC_RESET = 4'd3;

  // Input word
  typedef struct packed {
    logic [PACKED_W-1:0] packed_sizes;
    logic [CNT_W-1:0]    cluster_count;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [MEAN_W-1:0]  mean_size;
    logic               mean_valid;
    logic [TRUNC_W-1:0] trunc_mean_size;
    logic               trunc_valid;
  } out_word_t;

  // What the merging stage hands to the dividers
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] tsum;
    logic [CNT_W-1:0] taken;
  } merge_t;

  // ceil(2^22 / d); a zero divisor gives zero so the quotient reads zero
  function automatic logic [RECIP_W-1:0] recip_f(input logic [CNT_W-1:0] den);
    logic [RECIP_W-1:0] r;
    unique case (den)
      4'd1:    r = 23'd4194304;
      4'd2:    r = 23'd2097152;
      4'd3:    r = 23'd1398102;
      4'd4:    r = 23'd1048576;
      4'd5:    r = 23'd838861;
      4'd6:    r = 23'd699051;
      4'd7:    r = 23'd599187;
      4'd8:    r = 23'd524288;
      4'd9:    r = 23'd466034;
      4'd10:   r = 23'd419431;
      4'd11:   r = 23'd381301;
      4'd12:   r = 23'd349526;
      4'd13:   r = 23'd322639;
      4'd14:   r = 23'd299594;
      4'd15:   r = 23'd279621;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/tmcs_lane.sv
// One lane: ranks its own layer size among the non-zero sizes and
// flags it when it is one of the smallest `limit` of them. Uses tmcs_pkg.
module tmcs_lane import tmcs_pkg::*; #(
  parameter int NUM_LAYERS = NUM_LAYERS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF,
  parameter int LANE       = 0
) (
  input  logic [NUM_LAYERS*SIZE_BITS-1:0] sizes_i,
  input  logic [CNT_W-1:0]                limit_i,
  output logic                            sel_o
);

  logic [SIZE_BITS-1:0] own;
  logic [SIZE_BITS-1:0] other;
  logic [CNT_W-1:0]     rank;

  // Rank = non-zero sizes ahead of this one in a stable ascending order
  always_comb begin
    own  = sizes_i[LANE*SIZE_BITS +: SIZE_BITS];
    rank = '0;
    other = '0;
    for (int j = 0; j < NUM_LAYERS; j++) begin
      other = sizes_i[j*SIZE_BITS +: SIZE_BITS];
      if (other != '0 && (other < own || (other == own && j < LANE))) begin
        rank = rank + 1'b1;
      end
    end
    sel_o = (own != '0) && (rank < limit_i);
  end

endmodule

>>> sv/tmcs_merge.sv
// Merging stage: adds up all sizes, the selected sizes and the selected
// count from the lane flags. Uses tmcs_pkg.
module tmcs_merge import tmcs_pkg::*; #(
  parameter int NUM_LAYERS = NUM_LAYERS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic [NUM_LAYERS*SIZE_BITS-1:0] sizes_i,
  input  logic [NUM_LAYERS-1:0]           sel_i,
  output merge_t                          merge_o
);

  logic [SUM_W-1:0] size_ext;

  always_comb begin
    merge_o  = '0;
    size_ext = '0;
    for (int k = 0; k < NUM_LAYERS; k++) begin
      size_ext      = SUM_W'(sizes_i[k*SIZE_BITS +: SIZE_BITS]);
      merge_o.sum   = merge_o.sum + size_ext;
      if (sel_i[k]) begin
        merge_o.tsum  = merge_o.tsum + size_ext;
        merge_o.taken = merge_o.taken + CNT_W'(1);
      end
    end
  end

endmodule

>>> sv/tmcs_div.sv
// Small-divisor divider: scales a sum by 2^FRAC_BITS and divides by a
// 4-bit count through a reciprocal table and one multiply. Uses tmcs_pkg.
module tmcs_div import tmcs_pkg::*; (
  input  logic [SUM_W-1:0]  num_i,
  input  logic [CNT_W-1:0]  den_i,
  output logic [MEAN_W-1:0] quo_o
);

  logic [MEAN_W-1:0]         dividend;
  logic [RECIP_W-1:0]        recip;
  logic [MEAN_W+RECIP_W-1:0] prod;

  // Zero divisor has a zero reciprocal, so the quotient comes out zero
  always_comb begin
    dividend = {num_i, {FRAC_BITS{1'b0}}};
    recip    = recip_f(den_i);
    prod     = (MEAN_W+RECIP_W)'(dividend) * (MEAN_W+RECIP_W)'(recip);
    quo_o    = prod[RECIP_SHIFT +: MEAN_W];
  end

endmodule

>>> sv/truncated_mean_cluster_size.sv
// Truncated mean cluster size. Takes one track word per cycle and returns one
// result word for each accepted word: the plain mean (sum of all
// layer sizes over the cluster count) and the mean of the smallest non-zero
// sizes, at most trunc_count of them (0 acts as 1), both with 8 fraction
// bits. The four register stages are input capture, the per-layer ranking
// lanes, the merging adders and the reciprocal multipliers; the block
// sustains one word per cycle and stalls only when the output is held.
// Pipeline stages that hold no word never stall, so bubbles are squeezed out.
// Uses tmcs_pkg, tmcs_lane, tmcs_merge and tmcs_div.
module truncated_mean_cluster_size import tmcs_pkg::*; #(
  parameter int NUM_LAYERS = NUM_LAYERS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // config
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  // input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_word_i,
  // output channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_word_o
);

  localparam int SZ_W = NUM_LAYERS * SIZE_BITS;

  logic [CNT_W-1:0] trunc_q;
  logic [CNT_W-1:0] limit;

  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q;
  logic a_en, b_en, c_en, d_en;

  logic [SZ_W-1:0]       a_sizes_q, b_sizes_q;
  logic [CNT_W-1:0]      a_cnt_q, b_cnt_q, c_cnt_q;
  logic [NUM_LAYERS-1:0] sel, b_sel_q;
  merge_t                merge_d, c_merge_q;
  logic [MEAN_W-1:0]     mean_quo, trunc_quo;
  out_word_t             d_word_d, d_word_q;

  // Truncation limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trunc_q <= TRUNC_RESET;
    end else if (cfg_we_i) begin
      trunc_q <= cfg_wdata_i;
    end
  end

  assign limit = (trunc_q == '0) ? CNT_W'(1) : trunc_q;

  // Stage enables: a stage loads when it is empty or the next one loads
  assign d_en = !d_vld_q || !out_stall_i;
  assign c_en = !c_vld_q || d_en;
  assign b_en = !b_vld_q || c_en;
  assign a_en = !a_vld_q || b_en;

  assign in_stall_o = !a_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      if (a_en) a_vld_q <= in_valid_i;
      if (b_en) b_vld_q <= a_vld_q;
      if (c_en) c_vld_q <= b_vld_q;
      if (d_en) d_vld_q <= c_vld_q;
    end
  end

  // Ranking lanes, one per layer
  for (genvar k = 0; k < NUM_LAYERS; k++) begin : g_lane
    tmcs_lane #(
      .NUM_LAYERS (NUM_LAYERS),
      .SIZE_BITS  (SIZE_BITS),
      .LANE       (k)
    ) u_lane (
      .sizes_i (a_sizes_q),
      .limit_i (limit),
      .sel_o   (sel[k])
    );
  end

  // Merge of lane results
  tmcs_merge #(
    .NUM_LAYERS (NUM_LAYERS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_merge (
    .sizes_i (b_sizes_q),
    .sel_i   (b_sel_q),
    .merge_o (merge_d)
  );

  // Dividers for both means
  tmcs_div u_div_mean (
    .num_i (c_merge_q.sum),
    .den_i (c_cnt_q),
    .quo_o (mean_quo)
  );

  tmcs_div u_div_trunc (
    .num_i (c_merge_q.tsum),
    .den_i (c_merge_q.taken),
    .quo_o (trunc_quo)
  );

  // Result word assembly
  always_comb begin
    d_word_d.mean_size       = mean_quo;
    d_word_d.mean_valid      = (c_cnt_q != '0);
    d_word_d.trunc_mean_size = trunc_quo[TRUNC_W-1:0];
    d_word_d.trunc_valid     = (c_merge_q.taken != '0);
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (a_en) begin
      a_sizes_q <= in_word_i.packed_sizes[SZ_W-1:0];
      a_cnt_q   <= in_word_i.cluster_count;
    end
    if (b_en) begin
      b_sizes_q <= a_sizes_q;
      b_sel_q   <= sel;
      b_cnt_q   <= a_cnt_q;
    end
    if (c_en) begin
      c_merge_q <= merge_d;
      c_cnt_q   <= b_cnt_q;
    end
    if (d_en) begin
      d_word_q <= d_word_d;
    end
  end

  assign out_valid_o = d_vld_q;
  assign out_word_o  = d_word_q;

`ifndef SYNTH
  // An empty output stage never backs up the input
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output stage");

  // Truncated mean is non-zero exactly when flagged valid
  a_trunc_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.trunc_valid == (out_word_o.trunc_mean_size != '0)))
    else $error("trunc_valid disagrees with trunc_mean_size");

  // Plain mean reads zero when the cluster count was zero
  a_mean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.mean_valid || out_word_o.mean_size == '0))
    else $error("mean_size non-zero without mean_valid");

  // Selected sum is part of the full sum and empty exactly when nothing taken
  a_merge_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q |-> (c_merge_q.tsum <= c_merge_q.sum &&
                 (c_merge_q.taken == '0) == (c_merge_q.tsum == '0)))
    else $error("merge results inconsistent");
`endif

endmodule
